// File: rtl/lkv_pkg.sv
package lkv_pkg;

    localparam int KeyBits     = 8;
    localparam int ValueBits   = 64;
    localparam int CapBits     = 5;
    localparam int MaxEntries  = 16;
    localparam int SlotBits    = $clog2(MaxEntries);
    localparam int CountBits   = $clog2(MaxEntries + 1);
    localparam int CapReset    = 16;

    localparam logic OP_GET = 1'b0;
    localparam logic OP_PUT = 1'b1;

    typedef struct packed {
        logic                 operation;
        logic [KeyBits-1:0]   key;
        logic [ValueBits-1:0] value;
    } req_t;

    typedef struct packed {
        logic                 hit;
        logic [ValueBits-1:0] read_value;
        logic                 evicted;
        logic [KeyBits-1:0]   evicted_key;
    } rsp_t;

endpackage

// File: rtl/lkv_if.sv
interface lkv_req_if;
    import lkv_pkg::*;

    logic                 valid;
    logic                 ready;
    logic                 operation;
    logic [KeyBits-1:0]   key;
    logic [ValueBits-1:0] value;

    modport source (output valid, output operation, output key, output value, input ready);
    modport sink (input valid, input operation, input key, input value, output ready);
endinterface

interface lkv_rsp_if;
    import lkv_pkg::*;

    logic                 valid;
    logic                 ready;
    logic                 hit;
    logic [ValueBits-1:0] read_value;
    logic                 evicted;
    logic [KeyBits-1:0]   evicted_key;

    modport source (output valid, output hit, output read_value, output evicted,
                    output evicted_key, input ready);
    modport sink (input valid, input hit, input read_value, input evicted,
                  input evicted_key, output ready);
endinterface

// File: rtl/lkv_in_stage.sv
module lkv_in_stage (
    input  logic          clk,
    input  logic          rst_n,
    lkv_req_if.sink       req,
    input  logic          advance,
    output logic          valid,
    output lkv_pkg::req_t item
);
    import lkv_pkg::*;

    logic valid_reg;
    logic valid_next;
    req_t item_reg;

    // A held request leaves in the same cycle a new one arrives.
    assign req.ready  = !valid_reg || advance;
    assign valid_next = (req.valid && req.ready) || (valid_reg && !advance);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            item_reg.operation <= req.operation;
            item_reg.key       <= req.key;
            item_reg.value     <= req.value;
        end
    end

    assign valid = valid_reg;
    assign item  = item_reg;

endmodule

// File: rtl/lkv_core.sv
module lkv_core (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_write_en,
    input  logic [lkv_pkg::CapBits-1:0] cfg_write_data,
    input  logic                        advance,
    input  lkv_pkg::req_t               item,
    output lkv_pkg::rsp_t               result
);
    import lkv_pkg::*;

    logic [CapBits-1:0]   capacity_reg;
    logic [CountBits-1:0] occ_reg;
    logic [CountBits-1:0] occ_next;
    logic [KeyBits-1:0]   slot_key_reg   [MaxEntries];
    logic [ValueBits-1:0] slot_value_reg [MaxEntries];
    // Recency rank of each live slot: zero is the most recent.
    logic [SlotBits-1:0]  rank_reg       [MaxEntries];
    logic [SlotBits-1:0]  rank_next      [MaxEntries];

    logic [CountBits-1:0]  eff_cap;
    logic [CountBits-1:0]  threshold;
    logic [MaxEntries-1:0] live;
    logic [MaxEntries-1:0] match;
    logic [MaxEntries-1:0] is_tail;
    logic [SlotBits-1:0]   hit_slot;
    logic [SlotBits-1:0]   tail_slot;
    logic [SlotBits-1:0]   new_slot;
    logic [SlotBits-1:0]   target;
    logic                  hit;
    logic                  full;
    logic                  put_miss;
    logic                  evict;
    logic                  touch;

    function automatic logic [SlotBits-1:0] encode(input logic [MaxEntries-1:0] oh);
        logic [SlotBits-1:0] idx;
        idx = '0;
        for (int i = 0; i < MaxEntries; i++)
        begin
            if (oh[i])
            begin
                idx = idx | SlotBits'(i);
            end
        end
        return idx;
    endfunction

    always_comb
    begin
        if (capacity_reg == '0)
        begin
            eff_cap = CountBits'(1);
        end
        else if (int'(capacity_reg) > MaxEntries)
        begin
            eff_cap = CountBits'(MaxEntries);
        end
        else
        begin
            eff_cap = CountBits'(capacity_reg);
        end
    end

    // Slots below the occupancy count hold exactly the cached keys, so a
    // compare on every live slot stands in for the presence table.
    always_comb
    begin
        for (int i = 0; i < MaxEntries; i++)
        begin
            live[i]    = CountBits'(i) < occ_reg;
            match[i]   = live[i] && (slot_key_reg[i] == item.key);
            is_tail[i] = live[i] && (CountBits'(rank_reg[i]) == occ_reg - CountBits'(1));
        end
    end

    assign hit       = |match;
    assign hit_slot  = encode(match);
    assign tail_slot = encode(is_tail);
    assign full      = occ_reg >= eff_cap;
    assign put_miss  = (item.operation == OP_PUT) && !hit;
    assign evict     = put_miss && full;
    assign new_slot  = full ? tail_slot : occ_reg[SlotBits-1:0];
    assign target    = hit ? hit_slot : new_slot;
    assign threshold = hit ? CountBits'(rank_reg[hit_slot]) : occ_reg;
    assign touch     = hit || put_miss;
    assign occ_next  = (put_miss && !full) ? occ_reg + CountBits'(1) : occ_reg;

    // On a hit, every slot more recent than the touched one ages by one; on a put miss, every other live slot does.
    always_comb
    begin
        for (int i = 0; i < MaxEntries; i++)
        begin
            if (SlotBits'(i) == target)
            begin
                rank_next[i] = '0;
            end
            else if (live[i] && (CountBits'(rank_reg[i]) < threshold))
            begin
                rank_next[i] = rank_reg[i] + SlotBits'(1);
            end
            else
            begin
                rank_next[i] = rank_reg[i];
            end
        end
    end

    always_comb
    begin
        result.hit         = hit;
        result.read_value  = (hit && (item.operation == OP_GET)) ?
                             slot_value_reg[hit_slot] : '0;
        result.evicted     = evict;
        result.evicted_key = evict ? slot_key_reg[tail_slot] : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= CapBits'(CapReset);
            occ_reg      <= '0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                capacity_reg <= cfg_write_data;
            end
            if (advance)
            begin
                occ_reg <= occ_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && touch)
        begin
            for (int i = 0; i < MaxEntries; i++)
            begin
                rank_reg[i] <= rank_next[i];
            end
        end
        if (advance && put_miss)
        begin
            slot_key_reg[new_slot] <= item.key;
        end
        if (advance && (item.operation == OP_PUT))
        begin
            slot_value_reg[target] <= item.value;
        end
    end

endmodule

// File: rtl/lkv_out_stage.sv
module lkv_out_stage (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          load,
    input  lkv_pkg::rsp_t result,
    output logic          can_load,
    lkv_rsp_if.source     rsp
);
    import lkv_pkg::*;

    logic valid_reg;
    logic valid_next;
    rsp_t result_reg;

    assign can_load   = !valid_reg || rsp.ready;
    assign valid_next = load || (valid_reg && !rsp.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result;
        end
    end

    assign rsp.valid       = valid_reg;
    assign rsp.hit         = result_reg.hit;
    assign rsp.read_value  = result_reg.read_value;
    assign rsp.evicted     = result_reg.evicted;
    assign rsp.evicted_key = result_reg.evicted_key;

endmodule

// File: rtl/lru_key_value_cache.sv
// Channel  | Direction | Payload                                    | Handshake
// ---------+-----------+--------------------------------------------+------------
// req      | in        | operation, key, value                      | valid/ready
// rsp      | out       | hit, read_value, evicted, evicted_key      | valid/ready
// cfg      | in        | cfg_write_data (capacity)                  | cfg_write_en
//
// One request per cycle is taken unless the response side stalls; each result is registered in the response register.
// The lookup over all 16 slots and the recency update sit between the request
// register and the response register, so back-to-back requests see each other's updates.
// Reset empties the cache at once and sets capacity to 16; no clearing pass.
// A stalled response holds the response register; one more request waits in the
// request register, and then ready drops.
module lru_key_value_cache (
    input  logic                        clk,
    input  logic                        rst_n,
    lkv_req_if.sink                     req,
    lkv_rsp_if.source                   rsp,
    input  logic                        cfg_write_en,
    input  logic [lkv_pkg::CapBits-1:0] cfg_write_data
);
    import lkv_pkg::*;

    logic s1_valid;
    logic can_load;
    logic advance;
    req_t s1_item;
    rsp_t s1_result;

    assign advance = s1_valid && can_load;

    lkv_in_stage u_in_stage (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .advance (advance),
        .valid   (s1_valid),
        .item    (s1_item)
    );

    lkv_core u_core (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .advance        (advance),
        .item           (s1_item),
        .result         (s1_result)
    );

    lkv_out_stage u_out_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (advance),
        .result   (s1_result),
        .can_load (can_load),
        .rsp      (rsp)
    );

endmodule

// File: rtl/lkv_checker.sv
module lkv_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          rsp_valid,
    input logic                          rsp_ready,
    input logic                          rsp_hit,
    input logic [lkv_pkg::ValueBits-1:0] rsp_read_value,
    input logic                          rsp_evicted,
    input logic [lkv_pkg::KeyBits-1:0]   rsp_evicted_key
);
    import lkv_pkg::*;

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_hit)
            && $stable(rsp_read_value) && $stable(rsp_evicted) && $stable(rsp_evicted_key))
        else $error("stalled response changed");

    // Only a put that misses can evict.
    a_evict_no_hit: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_evicted |-> !rsp_hit)
        else $error("eviction reported on a hit");

    a_miss_value: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_hit |-> rsp_read_value == '0)
        else $error("read value nonzero on a miss");

    a_evict_key_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_evicted |-> rsp_evicted_key == '0)
        else $error("evicted key nonzero without eviction");

endmodule

bind lru_key_value_cache lkv_checker u_lkv_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .rsp_hit         (rsp.hit),
    .rsp_read_value  (rsp.read_value),
    .rsp_evicted     (rsp.evicted),
    .rsp_evicted_key (rsp.evicted_key)
);

// File: dv/lru_key_value_cache_tb.sv
`timescale 1ns / 100ps

module lru_key_value_cache_tb;
    import lkv_pkg::*;

    localparam int WatchdogLimit = 2000;
    localparam int RspHoldCycles = 80;
    localparam int KeySpace      = 1 << KeyBits;

    logic clk;
    logic rst_n;
    logic cfg_write_en;
    logic [CapBits-1:0] cfg_write_data;

    lkv_req_if req_if ();
    lkv_rsp_if rsp_if ();

    lru_key_value_cache u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .req            (req_if),
        .rsp            (rsp_if),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data)
    );

    // Predicted cache contents: recency order holds the cached keys, most recent first.
    logic                 key_cached [KeySpace];
    logic [ValueBits-1:0] cached_value [KeySpace];
    logic [KeyBits-1:0]   recency_order [$];
    logic [CapBits-1:0]   model_capacity;

    rsp_t pending_rsp_q [$];

    int   request_count;
    int   response_count;
    int   hit_count;
    int   eviction_count;
    int   capacity_writes;
    int   mismatch_count;
    int   stall_cycles;
    int   burst_left;
    logic pacing_on;
    logic hold_request;

    initial begin
        clk = 1'b0;
    end

    always #2 clk = ~clk;

    function automatic rsp_t predict_lru_access(input req_t item);
        rsp_t result;
        int   limit;
        int   pos;
        result = '0;
        if (model_capacity == 0)
        begin
            limit = 1;
        end
        else if (model_capacity > MaxEntries)
        begin
            limit = MaxEntries;
        end
        else
        begin
            limit = int'(model_capacity);
        end
        if (key_cached[item.key])
        begin
            result.hit = 1'b1;
            if (item.operation == OP_GET)
            begin
                result.read_value = cached_value[item.key];
            end
            else
            begin
                cached_value[item.key] = item.value;
            end
            for (pos = 0; pos < recency_order.size(); pos++)
            begin
                if (recency_order[pos] == item.key)
                begin
                    break;
                end
            end
            recency_order.delete(pos);
            recency_order.push_front(item.key);
        end
        else if (item.operation == OP_PUT)
        begin
            // A lowered capacity never shrinks the contents; a miss then swaps one entry.
            if (recency_order.size() >= limit)
            begin
                result.evicted     = 1'b1;
                result.evicted_key = recency_order.pop_back();
                key_cached[result.evicted_key] = 1'b0;
            end
            recency_order.push_front(item.key);
            key_cached[item.key]   = 1'b1;
            cached_value[item.key] = item.value;
        end
        return result;
    endfunction

    always @(posedge clk)
    begin : request_monitor
        req_t accepted;
        rsp_t predicted;
        if (rst_n && cfg_write_en)
        begin
            model_capacity = cfg_write_data;
        end
        if (rst_n && req_if.valid && req_if.ready)
        begin
            accepted.operation = req_if.operation;
            accepted.key       = req_if.key;
            accepted.value     = req_if.value;
            predicted = predict_lru_access(accepted);
            pending_rsp_q.push_back(predicted);
            request_count++;
            if (predicted.hit)
            begin
                hit_count++;
            end
            if (predicted.evicted)
            begin
                eviction_count++;
            end
        end
    end

    task automatic note_mismatch(input string field, input logic [63:0] want,
                                 input logic [63:0] got);
        mismatch_count++;
        if (mismatch_count <= 10)
        begin
            $display("Mismatch in %s at response %0d: expected %0h, got %0h",
                     field, response_count, want, got);
        end
    endtask

    always @(posedge clk)
    begin : response_checker
        rsp_t predicted;
        if (rst_n && rsp_if.valid && rsp_if.ready)
        begin
            response_count++;
            if (pending_rsp_q.size() == 0)
            begin
                note_mismatch("unrequested response", 64'd0, 64'd1);
            end
            else
            begin
                predicted = pending_rsp_q.pop_front();
                if (rsp_if.hit !== predicted.hit)
                begin
                    note_mismatch("hit", 64'(predicted.hit), 64'(rsp_if.hit));
                end
                if (rsp_if.read_value !== predicted.read_value)
                begin
                    note_mismatch("read_value", predicted.read_value, rsp_if.read_value);
                end
                if (rsp_if.evicted !== predicted.evicted)
                begin
                    note_mismatch("evicted", 64'(predicted.evicted), 64'(rsp_if.evicted));
                end
                if (rsp_if.evicted_key !== predicted.evicted_key)
                begin
                    note_mismatch("evicted_key", 64'(predicted.evicted_key),
                                  64'(rsp_if.evicted_key));
                end
            end
        end
    end

    always @(posedge clk)
    begin : watchdog
        if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
        begin
            stall_cycles = 0;
        end
        else
        begin
            stall_cycles++;
            if (stall_cycles >= WatchdogLimit)
            begin
                $display("Timeout: no request or response moved for %0d cycles",
                         WatchdogLimit);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // The response side cycles through its own stall modes; a long hold can be asked for.
    initial
    begin : response_sink
        int mode;
        int mode_left;
        int hold_left;
        int beat;
        mode      = 0;
        mode_left = 0;
        hold_left = 0;
        beat      = 0;
        rsp_if.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (mode_left == 0)
            begin
                mode      = $urandom_range(0, 3);
                mode_left = $urandom_range(50, 300);
            end
            mode_left--;
            beat++;
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_if.ready <= 1'b0;
            end
            else if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left    = RspHoldCycles - 1;
                rsp_if.ready <= 1'b0;
            end
            else
            begin
                case (mode)
                    0: rsp_if.ready <= 1'b1;
                    1: rsp_if.ready <= ($urandom_range(0, 4) != 0);
                    2: rsp_if.ready <= ($urandom_range(0, 3) == 0);
                    default: rsp_if.ready <= ((beat % 5) >= 2);
                endcase
            end
        end
    end

    task automatic send_request(input logic op, input logic [KeyBits-1:0] key,
                                input logic [ValueBits-1:0] value);
        req_if.valid     <= 1'b1;
        req_if.operation <= op;
        req_if.key       <= key;
        req_if.value     <= value;
        do
        begin
            @(posedge clk);
        end
        while (!req_if.ready);
        if (pacing_on)
        begin
            if (burst_left > 0)
            begin
                burst_left--;
            end
            if (burst_left == 0)
            begin
                req_if.valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
                burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 90)
                                                         : $urandom_range(1, 12);
            end
        end
    endtask

    task automatic wait_for_responses();
        req_if.valid <= 1'b0;
        @(posedge clk);
        while (pending_rsp_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (3) @(posedge clk);
    endtask

    task automatic write_capacity(input logic [CapBits-1:0] cap);
        cfg_write_en   <= 1'b1;
        cfg_write_data <= cap;
        @(posedge clk);
        cfg_write_en   <= 1'b0;
        capacity_writes++;
    endtask

    // Capacity zero acts as one, so the second put evicts the only entry.
    task automatic test_single_entry();
        send_request(OP_GET, 8'd0, 64'd0);
        wait_for_responses();
        write_capacity(5'd0);
        send_request(OP_PUT, 8'd3, 64'h0123_4567_89AB_CDEF);
        send_request(OP_PUT, 8'd4, '1);
        send_request(OP_GET, 8'd3, 64'd0);
        send_request(OP_GET, 8'd4, 64'd0);
        send_request(OP_PUT, 8'd4, 64'd0);
        send_request(OP_PUT, 8'd255, 64'h5555_5555_5555_5555);
        send_request(OP_GET, 8'd255, '1);
        wait_for_responses();
    endtask

    task automatic test_small_capacity();
        write_capacity(5'd2);
        send_request(OP_PUT, 8'd1, 64'hAAAA_AAAA_AAAA_AAAA);
        // Touching 255 leaves key 1 as the least recent entry.
        send_request(OP_GET, 8'd255, 64'd0);
        send_request(OP_PUT, 8'd2, 64'h8000_0000_0000_0000);
        send_request(OP_PUT, 8'd0, '1);
        send_request(OP_GET, 8'd0, 64'd0);
        send_request(OP_PUT, 8'd128, 64'd1);
        send_request(OP_GET, 8'd2, 64'd0);
        wait_for_responses();
        write_capacity(5'd31);
        send_request(OP_PUT, 8'd127, 64'h7FFF_FFFF_FFFF_FFFE);
        send_request(OP_GET, 8'd0, 64'd0);
        send_request(OP_GET, 8'd127, 64'd0);
        wait_for_responses();
    endtask

    task automatic run_random_phase(input logic [CapBits-1:0] cap, input int count);
        int                   n;
        int                   pool;
        int                   base;
        int                   put_pct;
        logic                 op;
        logic [KeyBits-1:0]   key;
        logic [ValueBits-1:0] value;
        write_capacity(cap);
        pool    = ((cap == 0) ? 1 : (cap > MaxEntries) ? MaxEntries : int'(cap))
                  + $urandom_range(1, 12);
        base    = $urandom_range(0, KeySpace - 1);
        put_pct = $urandom_range(30, 70);
        for (n = 0; n < count; n++)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                key = KeyBits'($urandom_range(0, KeySpace - 1));
            end
            else
            begin
                key = KeyBits'(base + $urandom_range(0, pool - 1));
            end
            op = ($urandom_range(0, 99) < put_pct) ? OP_PUT : OP_GET;
            case ($urandom_range(0, 9))
                0: value = '0;
                1: value = '1;
                default: value = {$urandom, $urandom};
            endcase
            send_request(op, key, value);
        end
        wait_for_responses();
    endtask

    task automatic test_random_traffic(input int phases);
        int p;
        for (p = 0; p < phases; p++)
        begin
            run_random_phase(CapBits'($urandom_range(0, 31)), 140);
        end
    endtask

    // Responses are held off while requests keep coming, so the input stalls.
    task automatic test_response_backpressure();
        int n;
        hold_request = 1'b1;
        pacing_on    = 1'b0;
        for (n = 0; n < 24; n++)
        begin
            send_request(n[0] ? OP_PUT : OP_GET, KeyBits'($urandom_range(0, 31)),
                         {$urandom, $urandom});
        end
        pacing_on = 1'b1;
        wait_for_responses();
    endtask

    initial
    begin
        rst_n            = 1'b0;
        cfg_write_en     = 1'b0;
        cfg_write_data   = '0;
        req_if.valid     = 1'b0;
        req_if.operation = OP_GET;
        req_if.key       = '0;
        req_if.value     = '0;
        hold_request     = 1'b0;
        pacing_on        = 1'b1;
        burst_left       = 8;
        request_count    = 0;
        response_count   = 0;
        hit_count        = 0;
        eviction_count   = 0;
        capacity_writes  = 0;
        mismatch_count   = 0;
        stall_cycles     = 0;
        model_capacity   = CapBits'(CapReset);
        foreach (key_cached[k])
        begin
            key_cached[k]   = 1'b0;
            cached_value[k] = '0;
        end

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        test_single_entry();
        test_small_capacity();
        run_random_phase(5'd16, 140);
        run_random_phase(5'd1, 140);
        test_response_backpressure();
        run_random_phase(5'd31, 140);
        run_random_phase(5'd17, 140);
        run_random_phase(5'd4, 140);
        run_random_phase(5'd0, 140);
        run_random_phase(5'd8, 140);
        test_random_traffic(2);
        run_random_phase(5'd16, 140);

        wait_for_responses();
        repeat (10) @(posedge clk);
        $display("Checked %0d requests across %0d capacity writes: %0d hits, %0d evictions.",
                 request_count, capacity_writes, hit_count, eviction_count);
        $display("Responses received: %0d, mismatches: %0d.", response_count, mismatch_count);
        if (mismatch_count == 0 && pending_rsp_q.size() == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
